>>> design/gcd_pkg.sv
// Shared constants, widths and the arctangent table of the great-circle distance core.
`default_nettype none
package gcd_pkg;

  localparam int ANGLE_FRAC_BITS = 23;
  localparam int CORDIC_STEPS    = 24;
  localparam int WORK_FRAC       = 29;

  localparam int DEG_W   = 40;
  localparam int MAG_W   = 36;
  localparam int HALF_MW = MAG_W / 2;
  localparam int ANG_W   = 34;
  localparam int RAD_K_W = 28;
  localparam int SQ_W    = 62;
  localparam int SQ_STEPS = 31;
  localparam int H_W     = 31;

  localparam int LAT_SHIFT  = WORK_FRAC - ANGLE_FRAC_BITS;
  localparam int DIFF_SHIFT = WORK_FRAC - ANGLE_FRAC_BITS - 1;

  localparam logic signed [DEG_W-1:0] FULL_Q29    = DEG_W'(64'sd360 <<< WORK_FRAC);
  localparam logic signed [DEG_W-1:0] HALF_Q29    = DEG_W'(64'sd180 <<< WORK_FRAC);
  localparam logic signed [DEG_W-1:0] QUARTER_Q29 = DEG_W'(64'sd90 <<< WORK_FRAC);

  localparam logic [RAD_K_W-1:0]    RAD_PER_DEG_Q33 = RAD_K_W'(149922641);
  localparam logic signed [ANG_W-1:0] CORDIC_GAIN_INV = ANG_W'(34'sh026DD3B6A);
  localparam logic [H_W-1:0]        ONE_Q30 = H_W'(31'h4000_0000);

  localparam int SC_LAT = CORDIC_STEPS + 4;
  localparam int HAV_LAT = 3;
  localparam int VLD_LEN = SC_LAT + HAV_LAT + SQ_STEPS + CORDIC_STEPS + 2;

  function automatic logic signed [ANG_W-1:0] atan_q30(input logic [4:0] idx);
    logic [31:0] v;
    unique case (idx)
      5'd0:  v = 32'h3243F6A8;
      5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;
      5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;
      5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;
      5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;
      5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;
      5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;
      5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;
      5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;
      5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;
      5'd23: v = 32'h0000007F;
      5'd24: v = 32'h0000003F;
      5'd25: v = 32'h0000001F;
      5'd26: v = 32'h0000000F;
      5'd27: v = 32'h00000008;
      5'd28: v = 32'h00000004;
      5'd29: v = 32'h00000002;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return ANG_W'(signed'({1'b0, v}));
  endfunction

endpackage
`default_nettype wire

>>> design/gcd_sincos.sv
// Angle reduction, degree-to-radian scaling and pipelined rotation CORDIC.
`default_nettype none
module gcd_sincos
  import gcd_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    en_i,
  input  wire logic signed [DEG_W-1:0] deg_i,
  output logic signed [ANG_W-1:0]      sin_o,
  output logic signed [ANG_W-1:0]      cos_o
);

  logic signed [DEG_W-1:0] wrap, fold;
  logic                    fold_neg;
  logic [MAG_W-1:0]        mag_d;

  always_comb begin
    wrap = deg_i;
    if (deg_i >= HALF_Q29) begin
      wrap = deg_i - FULL_Q29;
    end else if (deg_i < -HALF_Q29) begin
      wrap = deg_i + FULL_Q29;
    end
    fold     = wrap;
    fold_neg = 1'b0;
    if (wrap > QUARTER_Q29) begin
      fold     = HALF_Q29 - wrap;
      fold_neg = 1'b1;
    end else if (wrap < -QUARTER_Q29) begin
      fold     = -HALF_Q29 - wrap;
      fold_neg = 1'b1;
    end
    mag_d = fold[DEG_W-1] ? MAG_W'(-fold) : MAG_W'(fold);
  end

  // stage A: reduced magnitude
  logic [MAG_W-1:0] mag_q;
  logic             sgn_a_q, nc_a_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q   <= mag_d;
      sgn_a_q <= fold[DEG_W-1];
      nc_a_q  <= fold_neg;
    end
  end

  // stage B: partial products of the radian scaling
  logic [HALF_MW+RAD_K_W-1:0] lo_q, hi_q;
  logic                       sgn_b_q, nc_b_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lo_q    <= mag_q[HALF_MW-1:0] * RAD_PER_DEG_Q33;
      hi_q    <= mag_q[MAG_W-1:HALF_MW] * RAD_PER_DEG_Q33;
      sgn_b_q <= sgn_a_q;
      nc_b_q  <= nc_a_q;
    end
  end

  logic [63:0]             rad_sum;
  logic [31:0]             rad;
  assign rad_sum = {hi_q, HALF_MW'(0)} + 64'(lo_q);
  assign rad     = rad_sum[63:32];

  logic signed [ANG_W-1:0] x_q [CORDIC_STEPS+1];
  logic signed [ANG_W-1:0] y_q [CORDIC_STEPS+1];
  logic signed [ANG_W-1:0] z_q [CORDIC_STEPS+1];
  logic                    nc_q [CORDIC_STEPS+1];

  // stage C: rotation start
  assign x_q[0] = CORDIC_GAIN_INV;
  assign y_q[0] = '0;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      z_q[0]  <= sgn_b_q ? -ANG_W'(rad) : ANG_W'(rad);
      nc_q[0] <= nc_b_q;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
    logic signed [ANG_W-1:0] xs, ys, at;
    assign xs = x_q[i] >>> i;
    assign ys = y_q[i] >>> i;
    assign at = atan_q30(5'(i));
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!z_q[i][ANG_W-1]) begin
          x_q[i+1] <= x_q[i] - ys;
          y_q[i+1] <= y_q[i] + xs;
          z_q[i+1] <= z_q[i] - at;
        end else begin
          x_q[i+1] <= x_q[i] + ys;
          y_q[i+1] <= y_q[i] - xs;
          z_q[i+1] <= z_q[i] + at;
        end
        nc_q[i+1] <= nc_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_o <= y_q[CORDIC_STEPS];
      cos_o <= nc_q[CORDIC_STEPS] ? -x_q[CORDIC_STEPS] : x_q[CORDIC_STEPS];
    end
  end

endmodule
`default_nettype wire

>>> design/gcd_hav.sv
// Haversine term h and 1-h from the sines and cosines, clamped to [0,1].
`default_nettype none
module gcd_hav
  import gcd_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    en_i,
  input  wire logic signed [ANG_W-1:0] sin_dlat_i,
  input  wire logic signed [ANG_W-1:0] sin_dlng_i,
  input  wire logic signed [ANG_W-1:0] cos_lat1_i,
  input  wire logic signed [ANG_W-1:0] cos_lat2_i,
  output logic [H_W-1:0]               h_o,
  output logic [H_W-1:0]               hc_o
);

  logic signed [2*ANG_W-1:0] p_cc, p_bb, p_aa, p_t;
  logic signed [ANG_W-1:0]   cc_q, bb_q, aa_q, bb2_q, t_q;
  logic signed [ANG_W:0]     h_sum;
  logic [H_W-1:0]            h_d;

  assign p_cc = cos_lat1_i * cos_lat2_i;
  assign p_bb = sin_dlat_i * sin_dlat_i;
  assign p_aa = sin_dlng_i * sin_dlng_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cc_q <= ANG_W'(p_cc >>> 30);
      bb_q <= ANG_W'(p_bb >>> 30);
      aa_q <= ANG_W'(p_aa >>> 30);
    end
  end

  assign p_t = cc_q * aa_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q   <= ANG_W'(p_t >>> 30);
      bb2_q <= bb_q;
    end
  end

  assign h_sum = (ANG_W+1)'(bb2_q) + (ANG_W+1)'(t_q);

  always_comb begin
    if (h_sum[ANG_W]) begin
      h_d = '0;
    end else if (h_sum > (ANG_W+1)'(ONE_Q30)) begin
      h_d = ONE_Q30;
    end else begin
      h_d = H_W'(h_sum);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      h_o  <= h_d;
      hc_o <= ONE_Q30 - h_d;
    end
  end

endmodule
`default_nettype wire

>>> design/gcd_isqrt.sv
// Pipelined bitwise integer square root of a Q30 value shifted up by 30 bits.
`default_nettype none
module gcd_isqrt
  import gcd_pkg::*;
(
  input  wire logic           clk_i,
  input  wire logic           en_i,
  input  wire logic [H_W-1:0] val_i,
  output logic [H_W-1:0]      root_o
);

  logic [SQ_W-1:0] v_q   [SQ_STEPS+1];
  logic [SQ_W-1:0] res_q [SQ_STEPS+1];

  assign v_q[0]   = {1'b0, val_i, 30'b0};
  assign res_q[0] = '0;

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
    localparam logic [SQ_W-1:0] Bit = SQ_W'(1) << (2 * (SQ_STEPS - 1 - k));
    logic [SQ_W-1:0] trial;
    assign trial = res_q[k] + Bit;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (v_q[k] >= trial) begin
          v_q[k+1]   <= v_q[k] - trial;
          res_q[k+1] <= (res_q[k] >> 1) + Bit;
        end else begin
          v_q[k+1]   <= v_q[k];
          res_q[k+1] <= res_q[k] >> 1;
        end
      end
    end
  end

  assign root_o = res_q[SQ_STEPS][H_W-1:0];

endmodule
`default_nettype wire

>>> design/gcd_atan.sv
// Pipelined vectoring CORDIC giving the Q30 angle atan2(y, x).
`default_nettype none
module gcd_atan
  import gcd_pkg::*;
(
  input  wire logic           clk_i,
  input  wire logic           en_i,
  input  wire logic [H_W-1:0] y_i,
  input  wire logic [H_W-1:0] x_i,
  output logic signed [ANG_W-1:0] angle_o
);

  logic signed [ANG_W-1:0] x_q [CORDIC_STEPS+1];
  logic signed [ANG_W-1:0] y_q [CORDIC_STEPS+1];
  logic signed [ANG_W-1:0] z_q [CORDIC_STEPS+1];

  assign x_q[0] = ANG_W'(x_i);
  assign y_q[0] = ANG_W'(y_i);
  assign z_q[0] = '0;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vec
    logic signed [ANG_W-1:0] xs, ys, at;
    assign xs = x_q[i] >>> i;
    assign ys = y_q[i] >>> i;
    assign at = atan_q30(5'(i));
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (y_q[i] > 0) begin
          x_q[i+1] <= x_q[i] + ys;
          y_q[i+1] <= y_q[i] - xs;
          z_q[i+1] <= z_q[i] + at;
        end else begin
          x_q[i+1] <= x_q[i] - ys;
          y_q[i+1] <= y_q[i] + xs;
          z_q[i+1] <= z_q[i] - at;
        end
      end
    end
  end

  assign angle_o = z_q[CORDIC_STEPS];

endmodule
`default_nettype wire

>>> design/great_circle_distance_core.sv
// Top level: haversine great-circle distance pipeline with stream ports.
//
//   port group   dir  payload                                   request taken when
//   s_axis       in   lng Q9.23, lat Q8.23 (degrees)            tvalid & tready
//   m_axis       out  distance (1e-5 radius units)              tvalid & tready
//   cfg          in   sphere radius in 1e-3 units               we
//
// One request per cycle while m_axis does not stall; the pipeline includes two
// CORDIC chains of one step per stage and the 31-stage square root.
// Reset clears valid bits and restores the default radius.
// A stall on m_axis freezes every stage at once; s_axis tready follows it.
`default_nettype none
module great_circle_distance_core
  import gcd_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // [31:0] first_longitude, [62:32] first_latitude,
  // [94:63] second_longitude, [125:95] second_latitude
  input  wire logic [127:0] s_axis_tdata_i,
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // [31:0] distance
  output logic [31:0]       m_axis_tdata_o,
  input  wire logic         cfg_we_i,
  input  wire logic [23:0]  cfg_wdata_i
);

  logic en;
  logic out_valid_q;
  logic [31:0] out_data_q;

  assign en              = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  logic [23:0] radius_q;
  logic [31:0] r200_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= 24'd6378137;
      r200_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        radius_q <= cfg_wdata_i;
      end
      r200_q <= 32'(radius_q) * 32'd200;
    end
  end

  logic signed [31:0] lng1, lng2;
  logic signed [30:0] lat1, lat2;
  assign lng1 = s_axis_tdata_i[31:0];
  assign lat1 = s_axis_tdata_i[62:32];
  assign lng2 = s_axis_tdata_i[94:63];
  assign lat2 = s_axis_tdata_i[125:95];

  logic signed [DEG_W-1:0] dlat_q, dlng_q, lat1_q, lat2_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      dlat_q <= (DEG_W'(lat1) - DEG_W'(lat2)) <<< DIFF_SHIFT;
      dlng_q <= (DEG_W'(lng1) - DEG_W'(lng2)) <<< DIFF_SHIFT;
      lat1_q <= DEG_W'(lat1) <<< LAT_SHIFT;
      lat2_q <= DEG_W'(lat2) <<< LAT_SHIFT;
    end
  end

  logic vld_q  [VLD_LEN];
  logic zero_q [VLD_LEN];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < VLD_LEN; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else if (en) begin
      vld_q[0] <= s_axis_tvalid_i;
      for (int k = 1; k < VLD_LEN; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      zero_q[0] <= (lng1 == lng2) && (lat1 == lat2);
      for (int k = 1; k < VLD_LEN; k++) begin
        zero_q[k] <= zero_q[k-1];
      end
    end
  end

  logic signed [ANG_W-1:0] sin_dlat, sin_dlng, cos_lat1, cos_lat2;

  gcd_sincos u_sc_dlat (
    .clk_i (clk_i), .en_i (en), .deg_i (dlat_q), .sin_o (sin_dlat), .cos_o ()
  );
  gcd_sincos u_sc_dlng (
    .clk_i (clk_i), .en_i (en), .deg_i (dlng_q), .sin_o (sin_dlng), .cos_o ()
  );
  gcd_sincos u_sc_lat1 (
    .clk_i (clk_i), .en_i (en), .deg_i (lat1_q), .sin_o (), .cos_o (cos_lat1)
  );
  gcd_sincos u_sc_lat2 (
    .clk_i (clk_i), .en_i (en), .deg_i (lat2_q), .sin_o (), .cos_o (cos_lat2)
  );

  logic [H_W-1:0] h, hc, root_a, root_b;

  gcd_hav u_hav (
    .clk_i      (clk_i),
    .en_i       (en),
    .sin_dlat_i (sin_dlat),
    .sin_dlng_i (sin_dlng),
    .cos_lat1_i (cos_lat1),
    .cos_lat2_i (cos_lat2),
    .h_o        (h),
    .hc_o       (hc)
  );

  gcd_isqrt u_sqrt_a (.clk_i (clk_i), .en_i (en), .val_i (h),  .root_o (root_a));
  gcd_isqrt u_sqrt_b (.clk_i (clk_i), .en_i (en), .val_i (hc), .root_o (root_b));

  logic signed [ANG_W-1:0] theta;
  gcd_atan u_atan (
    .clk_i (clk_i), .en_i (en), .y_i (root_a), .x_i (root_b), .angle_o (theta)
  );

  logic [31:0] theta_pos;
  logic [63:0] prod_q;
  assign theta_pos = theta[ANG_W-1] ? 32'd0 : theta[31:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q <= r200_q * theta_pos;
    end
  end

  logic [64:0] rnd;
  logic [34:0] dist_rnd;
  assign rnd      = 65'(prod_q) + 65'(64'd1 << 29);
  assign dist_rnd = rnd[64:30];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vld_q[VLD_LEN-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (zero_q[VLD_LEN-1]) begin
        out_data_q <= '0;
      end else if (dist_rnd[34:32] != 3'd0) begin
        out_data_q <= 32'hFFFF_FFFF;
      end else begin
        out_data_q <= dist_rnd[31:0];
      end
    end
  end

endmodule
`default_nettype wire

>>> tb/sv/tb.sv
// Testbench for great_circle_distance_core: directed table plus random point pairs.
`timescale 1ns / 100ps
module tb;
  import gcd_pkg::*;

  localparam int LAT_LIM = 754974720;
  localparam int LNG_LIM = 1509949440;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [127:0] s_axis_tdata_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [31:0]  m_axis_tdata_o;
  logic         cfg_we_i = 1'b0;
  logic [23:0]  cfg_wdata_i = '0;

  great_circle_distance_core i_dut (
    .clk_i, .rst_ni, .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o, .cfg_we_i, .cfg_wdata_i
  );

  typedef struct packed {
    logic signed [30:0] lat2;
    logic signed [31:0] lng2;
    logic signed [30:0] lat1;
    logic signed [31:0] lng1;
  } point_pair_t;

  typedef struct {
    point_pair_t pair;
    logic        known;
    logic [31:0] dist_exp;
  } dir_row_t;

  logic [23:0] radius_milli;
  logic [31:0] dist_q[$];
  int          n_err = 0;
  int          hold_long = 0;
  int          quiet_send = 1;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50_000_000;
    $display("great_circle_distance_core test failed");
    $finish;
  end

  function automatic longint sar(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint arctan_q30(int i);
    return longint'(atan_q30(5'(i)));
  endfunction

  function automatic void cordic_sin_cos(longint deg, int frac,
                                         output longint s, output longint c);
    longint full, half, quarter, m, r, x, y, z, xs, ys;
    logic neg_cos;
    longint unsigned mag;
    full = longint'(360) <<< 29;
    half = longint'(180) <<< 29;
    quarter = longint'(90) <<< 29;
    neg_cos = 1'b0;
    m = deg <<< (29 - frac);
    m = m % full;
    if (m < 0) m += full;
    if (m >= half) m -= full;
    if (m > quarter) begin
      m = half - m;
      neg_cos = 1'b1;
    end else if (m < -quarter) begin
      m = -half - m;
      neg_cos = 1'b1;
    end
    mag = (m < 0) ? -m : m;
    r = longint'((mag * 64'd149922641) >> 32);
    if (m < 0) r = -r;
    x = 64'sh26DD3B6A;
    y = 0;
    z = r;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = sar(x, i);
      ys = sar(y, i);
      if (z >= 0) begin
        x -= ys; y += xs; z -= arctan_q30(i);
      end else begin
        x += ys; y -= xs; z += arctan_q30(i);
      end
    end
    s = y;
    c = neg_cos ? -x : x;
  endfunction

  function automatic longint vector_angle(longint yv, longint xv);
    longint x, y, z, xs, ys;
    x = xv;
    y = yv;
    z = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = sar(x, i);
      ys = sar(y, i);
      if (y > 0) begin
        x += ys; y -= xs; z += arctan_q30(i);
      end else begin
        x -= ys; y += xs; z -= arctan_q30(i);
      end
    end
    return z;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic [31:0] predict_distance(point_pair_t p, logic [23:0] rad);
    longint sa, ca, sb, cb, s1, c1, s2, c2, cc, h, theta;
    longint unsigned a, b, d;
    if (p.lng1 == p.lng2 && p.lat1 == p.lat2) return '0;
    cordic_sin_cos(longint'(p.lat1) - longint'(p.lat2), ANGLE_FRAC_BITS + 1, sb, cb);
    cordic_sin_cos(longint'(p.lng1) - longint'(p.lng2), ANGLE_FRAC_BITS + 1, sa, ca);
    cordic_sin_cos(longint'(p.lat1), ANGLE_FRAC_BITS, s1, c1);
    cordic_sin_cos(longint'(p.lat2), ANGLE_FRAC_BITS, s2, c2);
    cc = sar(c1 * c2, 30);
    h = sar(sb * sb, 30) + sar(cc * sar(sa * sa, 30), 30);
    if (h < 0) h = 0;
    if (h > (64'sd1 << 30)) h = 64'sd1 << 30;
    a = int_sqrt(longint'(h) << 30);
    b = int_sqrt(((64'sd1 << 30) - h) << 30);
    theta = vector_angle(longint'(a), longint'(b));
    if (theta < 0) theta = 0;
    d = (longint'(rad) * 200 * longint'(theta) + (64'd1 << 29)) >> 30;
    if (d > 64'hFFFF_FFFF) d = 64'hFFFF_FFFF;
    return d[31:0];
  endfunction

  function automatic point_pair_t rand_pair();
    point_pair_t p;
    int sel;
    sel = $urandom_range(0, 9);
    p.lng1 = $urandom;
    p.lat1 = 31'($urandom);
    p.lng2 = $urandom;
    p.lat2 = 31'($urandom);
    if (sel < 6) begin
      p.lng1 = $signed($urandom_range(0, 2 * LNG_LIM)) - LNG_LIM;
      p.lng2 = $signed($urandom_range(0, 2 * LNG_LIM)) - LNG_LIM;
      p.lat1 = 31'($signed($urandom_range(0, 2 * LAT_LIM)) - LAT_LIM);
      p.lat2 = 31'($signed($urandom_range(0, 2 * LAT_LIM)) - LAT_LIM);
    end else if (sel < 8) begin
      // nearby points
      p.lng2 = p.lng1 + $signed($urandom_range(0, 2000)) - 1000;
      p.lat2 = p.lat1 + 31'($signed($urandom_range(0, 2000)) - 1000);
    end else if (sel == 8) begin
      p.lng2 = p.lng1;
      p.lat2 = p.lat1;
    end
    return p;
  endfunction

  task automatic send_pair(point_pair_t p);
    int n;
    n = $urandom_range(0, 17) * quiet_send;
    if (n > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    s_axis_tdata_i  <= {2'b00, p};
    s_axis_tvalid_i <= 1'b1;
    dist_q.push_back(predict_distance(p, radius_milli));
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (dist_q.size() != 0) @(posedge clk_i);
    repeat (2 * CORDIC_STEPS + 60) @(posedge clk_i);
  endtask

  task automatic write_radius(logic [23:0] v);
    cfg_wdata_i <= v;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    radius_milli = v;
  endtask

  // receiver with random stalls and one long hold-off
  initial begin
    int wait_n;
    logic [31:0] exp_d;
    @(posedge rst_ni);
    forever begin
      if (hold_long > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (hold_long) @(posedge clk_i);
        hold_long = 0;
      end
      wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      if (wait_n > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (wait_n) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      if (dist_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected distance %0d", m_axis_tdata_o);
      end else begin
        exp_d = dist_q.pop_front();
        if (m_axis_tdata_o !== exp_d) begin
          n_err++;
          if (n_err <= 10)
            $display("distance mismatch: expected %0d actual %0d", exp_d, m_axis_tdata_o);
        end
      end
    end
  end

  initial begin
    dir_row_t rows[$];
    dir_row_t r;
    logic [23:0] radii[5];
    radius_milli = 24'd6378137;
    radii = '{24'd1, 24'hFFFFFF, 24'd1000, 24'd6378137, 24'd424242};
    r.known = 1'b1; r.dist_exp = '0;
    r.pair = '{lat2: 31'sd0, lng2: 32'sd0, lat1: 31'sd0, lng1: 32'sd0};
    rows.push_back(r);
    r.pair = '{lat2: -31'sd754974720, lng2: 32'sd1509949440,
               lat1: -31'sd754974720, lng1: 32'sd1509949440};
    rows.push_back(r);
    r.pair = '{lat2: 31'h7FFF_FFFF, lng2: 32'hFFFF_FFFF,
               lat1: 31'h7FFF_FFFF, lng1: 32'hFFFF_FFFF};
    rows.push_back(r);
    r.known = 1'b0;
    r.pair = '{lat2: -31'sd754974720, lng2: 32'sd0, lat1: 31'sd754974720, lng1: 32'sd0};
    rows.push_back(r);
    r.pair = '{lat2: 31'sd0, lng2: 32'sd1509949440, lat1: 31'sd0, lng1: -32'sd1509949440};
    rows.push_back(r);
    r.pair = '{lat2: 31'sd0, lng2: 32'sd1509949440, lat1: 31'sd0, lng1: 32'sd0};
    rows.push_back(r);
    r.pair = '{lat2: 31'sd1, lng2: 32'sd0, lat1: 31'sd0, lng1: 32'sd0};
    rows.push_back(r);
    r.pair = '{lat2: 31'sd0, lng2: 32'sd1, lat1: 31'sd0, lng1: 32'sd0};
    rows.push_back(r);
    r.pair = '{lat2: 31'h4000_0000, lng2: 32'h8000_0000, lat1: 31'h3FFF_FFFF,
               lng1: 32'h7FFF_FFFF};
    rows.push_back(r);
    r.pair = '{lat2: 31'sd100000000, lng2: 32'hB2D0_5E00, lat1: -31'sd900000000,
               lng1: -32'sd2000000000};
    rows.push_back(r);
    r.pair = '{lat2: 31'sd754974720, lng2: 32'sd123456789, lat1: 31'sd754974720,
               lng1: -32'sd987654321};
    rows.push_back(r);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].known &&
          predict_distance(rows[i].pair, radius_milli) !== rows[i].dist_exp) begin
        n_err++;
        $display("predictor disagrees on row %0d", i);
      end
      send_pair(rows[i].pair);
    end
    drain();

    // long receiver hold-off while sender streams back to back
    quiet_send = 0;
    hold_long = 300;
    repeat (150) send_pair(rand_pair());
    quiet_send = 1;
    drain();

    foreach (radii[k]) begin
      write_radius(radii[k]);
      repeat (200) send_pair(rand_pair());
      drain();
    end

    if (n_err == 0 && dist_q.size() == 0) begin
      $display("great_circle_distance_core test passed");
    end else begin
      $display("great_circle_distance_core test failed");
    end
    $finish;
  end

endmodule
